@@ src/llt_pkg.sv @@
// ----------------------------------------------------------------------------
// llt_pkg: shared types and constants of the lease lock table
// Command, status and state codes, request and response words, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package llt_pkg;

   localparam int unsigned TableEntriesDefault = 16;
   localparam int unsigned TagBitsDefault      = 32;
   localparam int unsigned HolderBitsDefault   = 16;

   typedef enum logic [2:0] {
      MODE_ACQUIRE = 3'd0,
      MODE_RELEASE = 3'd1,
      MODE_RENEW   = 3'd2,
      MODE_FORCE   = 3'd3,
      MODE_QUERY   = 3'd4,
      MODE_SWEEP   = 3'd5,
      MODE_CLEAR   = 3'd6,
      MODE_STATS   = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_LOCKED   = 3'd1,
      ST_NOT_HELD = 3'd2,
      ST_MISMATCH = 3'd3,
      ST_INVALID  = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_WALK,
      FSM_HOLD
   } fsm_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] resource_tag;
      logic [15:0] holder;
      logic [31:0] lease_seconds;
      logic [31:0] now_seconds;
      logic        clear_all;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        is_held;
      logic [15:0] owner;
      logic [31:0] taken_at;
      logic [31:0] lease_now;
      logic [32:0] expiry_time;
      logic [15:0] renewals;
      logic [4:0]  swept_count;
      logic [4:0]  active_count;
      logic [31:0] acquire_total;
      logic [31:0] contention_total;
      logic [31:0] expiry_total;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture request word
      logic lookup;  // apply a single-entry command
      logic step;    // process one entry of a walk
      logic finish;  // build response word
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic walk_mode;  // request is sweep or clear
      logic walk_last;  // walk pointer on the last entry
   } stat_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      sat_inc32 = (v == '1) ? v : v + 32'd1;
   endfunction

endpackage

@@ src/llt_ctrl.sv @@
// ----------------------------------------------------------------------------
// llt_ctrl: sequencer of the lease lock table
// Accepts a request word, runs a lookup or a walk, then holds the response.
// ----------------------------------------------------------------------------
module llt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  llt_pkg::stat_type stat,
   output llt_pkg::cmd_type  cmd
);
   import llt_pkg::*;

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_LOOKUP;
         end
         FSM_LOOKUP: begin
            state_in = stat.walk_mode ? FSM_WALK : FSM_HOLD;
         end
         FSM_WALK: begin
            if (stat.walk_last) state_in = FSM_HOLD;
         end
         FSM_HOLD: begin
            if (rsp_ready) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == FSM_IDLE);
      rsp_valid  = (state_ff == FSM_HOLD);
      cmd.load   = (state_ff == FSM_IDLE) && req_valid;
      cmd.lookup = (state_ff == FSM_LOOKUP) && !stat.walk_mode;
      cmd.step   = (state_ff == FSM_WALK);
      cmd.finish = ((state_ff == FSM_LOOKUP) && !stat.walk_mode) ||
                   ((state_ff == FSM_WALK) && stat.walk_last);
   end

endmodule

@@ src/llt_dp.sv @@
// ----------------------------------------------------------------------------
// llt_dp: entry store, lookup and counters of the lease lock table
// Associative tag match over the valid bits; sweep and clear walk entries.
// ----------------------------------------------------------------------------
module llt_dp #(
   parameter int unsigned TABLE_ENTRIES = llt_pkg::TableEntriesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  llt_pkg::req_type  req_word,
   input  llt_pkg::cmd_type  cmd,
   output llt_pkg::stat_type stat,
   output llt_pkg::rsp_type  rsp_word
);
   import llt_pkg::*;

   localparam int unsigned IdxBits = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CntBits = $clog2(TABLE_ENTRIES + 1);

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0] tag_ff     [TABLE_ENTRIES];
   logic [15:0] owner_ff   [TABLE_ENTRIES];
   logic [31:0] taken_ff   [TABLE_ENTRIES];
   logic [31:0] lease_ff   [TABLE_ENTRIES];
   logic [32:0] expiry_ff  [TABLE_ENTRIES];
   logic [15:0] renew_ff   [TABLE_ENTRIES];

   req_type            req_ff;
   rsp_type            rsp_ff, rsp_in;
   logic [CntBits-1:0] active_ff;
   logic [31:0]        acq_ff, acq_in, cont_ff, cont_in, exp_ff, exp_in;
   logic [IdxBits-1:0] ptr_ff;
   logic [4:0]         swept_ff, swept_in;
   logic [2:0]         st_ff, st_in;
   logic               held_ff, held_in;
   logic [IdxBits-1:0] hit_idx_ff;

   // lookup
   logic               hit, free_ok, hit_exp, ids_ok, wr_en, wr_renew;
   logic [IdxBits-1:0] hit_idx, free_idx, wr_idx;
   logic [32:0]        new_exp;
   logic               walk_exp, walk_drop;

   always_comb begin
      hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == req_ff.resource_tag) begin
            hit = 1'b1; hit_idx = IdxBits'(i);
         end
         if (!valid_ff[i]) begin
            free_ok = 1'b1; free_idx = IdxBits'(i);
         end
      end
   end

   assign hit_exp = (lease_ff[hit_idx] != '0) &&
                    ({1'b0, req_ff.now_seconds} >= expiry_ff[hit_idx]);
   assign ids_ok  = (req_ff.resource_tag != '0) && (req_ff.holder != '0);
   assign new_exp = {1'b0, req_ff.now_seconds} + {1'b0, req_ff.lease_seconds};
   assign walk_exp = (lease_ff[ptr_ff] != '0) &&
                     ({1'b0, req_ff.now_seconds} >= expiry_ff[ptr_ff]);

   always_comb begin
      valid_in  = valid_ff;
      acq_in    = acq_ff;
      cont_in   = cont_ff;
      exp_in    = exp_ff;
      swept_in  = swept_ff;
      st_in     = st_ff;
      held_in   = held_ff;
      wr_en     = 1'b0;
      wr_renew  = 1'b0;
      wr_idx    = hit_idx;
      walk_drop = 1'b0;
      if (cmd.load) begin
         swept_in = '0; st_in = ST_OK; held_in = 1'b0;
      end
      if (cmd.lookup) begin
         case (mode_type'(req_ff.mode))
            MODE_ACQUIRE, MODE_FORCE: begin
               if (!ids_ok) begin
                  st_in = ST_INVALID;
               end else if (hit && !hit_exp) begin
                  st_in = ST_LOCKED;
                  if (req_ff.mode == MODE_ACQUIRE) cont_in = sat_inc32(cont_ff);
               end else if (hit && req_ff.mode == MODE_FORCE) begin
                  wr_en = 1'b1;
               end else begin
                  // acquire on an expired entry frees it first; lowest free slot wins
                  if (hit) begin
                     valid_in[hit_idx] = 1'b0;
                     exp_in = sat_inc32(exp_ff);
                     wr_idx = (free_ok && free_idx < hit_idx) ? free_idx : hit_idx;
                     wr_en  = 1'b1;
                  end else if (free_ok) begin
                     wr_idx = free_idx; wr_en = 1'b1;
                  end else begin
                     st_in = ST_FULL;
                  end
               end
               if (wr_en) begin
                  valid_in[wr_idx] = 1'b1;
                  acq_in = sat_inc32(acq_ff);
               end
            end
            MODE_RELEASE, MODE_RENEW: begin
               if (!ids_ok) st_in = ST_INVALID;
               else if (!hit) st_in = ST_NOT_HELD;
               else if (owner_ff[hit_idx] != req_ff.holder) st_in = ST_MISMATCH;
               else if (req_ff.mode == MODE_RELEASE) valid_in[hit_idx] = 1'b0;
               else wr_renew = 1'b1;
            end
            MODE_QUERY: begin
               if (req_ff.resource_tag == '0) st_in = ST_INVALID;
               else if (!hit || hit_exp) st_in = ST_NOT_HELD;
               else held_in = 1'b1;
            end
            default: ;
         endcase
      end
      if (cmd.step && valid_ff[ptr_ff]) begin
         if (req_ff.mode == MODE_CLEAR && req_ff.clear_all) begin
            walk_drop = 1'b1;
         end else if (walk_exp) begin
            walk_drop = 1'b1;
            if (req_ff.mode == MODE_SWEEP) begin
               swept_in = swept_ff + 5'd1;
               exp_in   = sat_inc32(exp_ff);
            end
         end
         if (walk_drop) valid_in[ptr_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         active_ff <= '0;
         acq_ff    <= '0;
         cont_ff   <= '0;
         exp_ff    <= '0;
         ptr_ff    <= '0;
      end else begin
         valid_ff  <= valid_in;
         acq_ff    <= acq_in;
         cont_ff   <= cont_in;
         exp_ff    <= exp_in;
         active_ff <= CntBits'($countones(valid_in));
         if (cmd.load) ptr_ff <= '0;
         else if (cmd.step) ptr_ff <= ptr_ff + IdxBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_word;
      swept_ff <= swept_in;
      st_ff    <= st_in;
      held_ff  <= held_in;
      if (cmd.lookup) hit_idx_ff <= hit_idx;
      if (wr_en) begin
         tag_ff[wr_idx]    <= req_ff.resource_tag;
         owner_ff[wr_idx]  <= req_ff.holder;
         taken_ff[wr_idx]  <= req_ff.now_seconds;
         lease_ff[wr_idx]  <= req_ff.lease_seconds;
         expiry_ff[wr_idx] <= new_exp;
         renew_ff[wr_idx]  <= '0;
      end
      if (wr_renew) begin
         lease_ff[hit_idx]  <= req_ff.lease_seconds;
         expiry_ff[hit_idx] <= new_exp;
         if (renew_ff[hit_idx] != '1) renew_ff[hit_idx] <= renew_ff[hit_idx] + 16'd1;
      end
   end

   // response built once the command is done; counters are read as they stand
   always_comb begin
      rsp_in = '0;
      rsp_in.status = st_ff;
      if (held_ff) begin
         rsp_in.is_held     = 1'b1;
         rsp_in.owner       = owner_ff[hit_idx_ff];
         rsp_in.taken_at    = taken_ff[hit_idx_ff];
         rsp_in.lease_now   = lease_ff[hit_idx_ff];
         rsp_in.expiry_time = expiry_ff[hit_idx_ff];
         rsp_in.renewals    = renew_ff[hit_idx_ff];
      end
      if (req_ff.mode == MODE_SWEEP) rsp_in.swept_count = swept_ff;
      if (req_ff.mode == MODE_STATS) begin
         rsp_in.active_count     = 5'(active_ff);
         rsp_in.acquire_total    = acq_ff;
         rsp_in.contention_total = cont_ff;
         rsp_in.expiry_total     = exp_ff;
      end
   end

   logic fin_d_ff;
   always_ff @(posedge clock) begin
      if (reset) fin_d_ff <= 1'b0;
      else       fin_d_ff <= cmd.finish;
      if (fin_d_ff) rsp_ff <= rsp_in;
   end

   assign stat.walk_mode = (req_ff.mode == MODE_SWEEP) || (req_ff.mode == MODE_CLEAR);
   assign stat.walk_last = (ptr_ff == IdxBits'(TABLE_ENTRIES - 1));
   assign rsp_word = fin_d_ff ? rsp_in : rsp_ff;

endmodule

@@ src/lease_lock_table.sv @@
// ----------------------------------------------------------------------------
// lease_lock_table: table of leased locks with expiry
// Top level: sequencer plus entry datapath behind valid/ready channels.
// ----------------------------------------------------------------------------
// One request word is taken at a time. Acquire, release, renew, force acquire,
// query and statistics pass through a capture state, a lookup state that does
// the associative lookup and update, and a response state.
// Sweep and clear pass the lookup state idle, then walk the table one entry a
// cycle and go to the response state. A new word is taken the cycle after the
// response word is taken. The response is held until taken.
// An expiry of 0 lease never fires; otherwise an entry is expired once
// now_seconds reaches its stored 33-bit expiry. Counters saturate.
module lease_lock_table #(
   parameter int unsigned TABLE_ENTRIES = llt_pkg::TableEntriesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  llt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output llt_pkg::rsp_type rsp_data
);
   import llt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   llt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   llt_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_data)
   );

   // never ready while a response word is pending
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   // lookup commands and walk steps never overlap
   assert property (@(posedge clock) disable iff (reset) !(cmd.lookup && cmd.step))
      else $error("lookup and walk step together");

   // a response is valid only after work finished
   assert property (@(posedge clock) disable iff (reset) $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("response without finish");

endmodule
